[hw/rtl/wma_pkg.sv]
// ----------------------------------------------------------------------------
// wma_pkg: shared types and constants of the windowed moving average
// Holds the fixed field widths, command codes, the status flag struct and the
// state types of the front and back controllers.
// ----------------------------------------------------------------------------
package wma_pkg;

    // Fixed widths of the window length register and the average output.
    localparam int LEN_W = 7;
    localparam int AVG_W = 40;

    // Window length after reset.
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

    // Command codes carried in the func field.
    localparam logic FUNC_PUT   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Status that travels with every request from the front to the back.
    typedef struct packed {
        logic updated;
        logic window_full;
    } t_flags;

    // Front controller: wait for a request, then apply it to the window.
    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } t_front_state;

    // Back controller: fetch a job, divide bit by bit, hand the result over.
    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DONE
    } t_back_state;

endpackage

[hw/rtl/windowed_moving_average.sv]
// ----------------------------------------------------------------------------
// windowed_moving_average: mean of the most recent samples
// Keeps up to the configured window length of unsigned samples and reports
// their mean as fixed point with FRACTION_BITS fraction bits, truncated.
//
// Each request is either a put of a new sample or a clear of the updated
// flag, and each gives exactly one result: the average after the request,
// the sticky updated flag and whether the window is full. Writing the window
// length (clamped to 1..MAX_WINDOW, zero counts as one) empties the window
// but keeps the updated flag. The front captures a request and applies it
// once the job queue has room, reading the oldest sample from the ring. The
// back divides bit-serially and takes a new job only after the result of the
// last one has moved into the result register. A two-entry job queue lets
// the front take further requests while a division runs, and the result
// register lets the next division start while a result waits to be popped.
// ----------------------------------------------------------------------------
module windowed_moving_average
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW    = 64,
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Window length writes
    input  logic                   valid,
    output logic                   ready,
    input  logic [LEN_W-1:0]       i_window_len,
    // Requests
    input  logic                   push,
    output logic                   full,
    input  logic                   i_func,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // Results
    output logic                   empty,
    input  logic                   pop,
    output logic [AVG_W-1:0]       o_average,
    output logic                   o_updated,
    output logic                   o_window_full
);

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int FLAG_W  = $bits(t_flags);
    localparam int JOB_W   = SUM_W + CNT_W + FLAG_W;
    localparam int Q_DEPTH = 2;

    logic             f_job_valid;
    logic             f_job_ready;
    logic [SUM_W-1:0] f_job_sum;
    logic [CNT_W-1:0] f_job_cnt;
    t_flags           f_job_flags;
    logic             b_job_valid;
    logic             b_job_ready;
    logic [JOB_W-1:0] q_out;
    logic [SUM_W-1:0] b_job_sum;
    logic [CNT_W-1:0] b_job_cnt;
    t_flags           b_job_flags;

    // Request intake and window bookkeeping.
    wma_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (valid),
        .o_cfg_ready (ready),
        .i_cfg_len   (i_window_len),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_sample    (i_sample),
        .o_job_valid (f_job_valid),
        .i_job_ready (f_job_ready),
        .o_job_sum   (f_job_sum),
        .o_job_cnt   (f_job_cnt),
        .o_job_flags (f_job_flags)
    );

    // Job queue between the two halves.
    wma_queue #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_job_valid),
        .o_wr_ready (f_job_ready),
        .i_wr_data  ({f_job_sum, f_job_cnt, f_job_flags}),
        .o_rd_valid (b_job_valid),
        .i_rd_ready (b_job_ready),
        .o_rd_data  (q_out)
    );

    assign b_job_sum   = q_out[JOB_W-1 -: SUM_W];
    assign b_job_cnt   = q_out[FLAG_W +: CNT_W];
    assign b_job_flags = t_flags'(q_out[FLAG_W-1:0]);

    // Divider and result register.
    wma_back #(
        .MAX_WINDOW    (MAX_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (b_job_valid),
        .o_job_ready   (b_job_ready),
        .i_job_sum     (b_job_sum),
        .i_job_cnt     (b_job_cnt),
        .i_job_flags   (b_job_flags),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_average     (o_average),
        .o_updated     (o_updated),
        .o_window_full (o_window_full)
    );

endmodule

[hw/rtl/wma_front.sv]
// ----------------------------------------------------------------------------
// wma_front: request intake and window bookkeeping
// Accepts requests, keeps the sample ring, running sum, fill count, oldest
// pointer and updated flag, and issues one divide job per request.
// ----------------------------------------------------------------------------
module wma_front
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Window length writes
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [LEN_W-1:0]                         i_cfg_len,
    // Requests
    input  logic                                     i_push,
    output logic                                     o_full,
    input  logic                                     i_func,
    input  logic [SAMPLE_BITS-1:0]                   i_sample,
    // Divide jobs
    output logic                                     o_job_valid,
    input  logic                                     i_job_ready,
    output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0] o_job_sum,
    output logic [$clog2(MAX_WINDOW+1)-1:0]          o_job_cnt,
    output t_flags                                   o_job_flags
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Clamp a written window length to the range 1 to MAX_WINDOW.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w == '0) begin
            w = CMP_W'(1);
        end
        if (w > CMP_W'(MAX_WINDOW)) begin
            w = CMP_W'(MAX_WINDOW);
        end
        return w[CNT_W-1:0];
    endfunction

    t_front_state           r_state, n_state;
    logic                   r_func;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [PTR_W-1:0]       r_oldest, n_oldest;
    logic                   r_flag, n_flag;
    logic [CNT_W-1:0]       r_len;
    logic [CNT_W-1:0]       oldest_inc;
    logic                   accept;
    logic                   do_update;
    logic                   cfg_we;
    logic                   wr_en;
    logic [PTR_W-1:0]       wr_addr;
    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    // Next state of the controller.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_state = F_UPDATE;
                end
            end
            F_UPDATE: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Handshake outputs and strobes of the controller.
    always_comb begin
        accept      = 1'b0;
        o_full      = 1'b1;
        o_cfg_ready = 1'b0;
        o_job_valid = 1'b0;
        do_update   = 1'b0;
        case (r_state)
            F_IDLE: begin
                accept      = i_push;
                o_full      = 1'b0;
                o_cfg_ready = 1'b1;
            end
            F_UPDATE: begin
                o_job_valid = 1'b1;
                do_update   = i_job_ready;
            end
            default: begin
                o_full = 1'b1;
            end
        endcase
    end

    assign cfg_we     = i_cfg_valid && o_cfg_ready;
    assign oldest_inc = CNT_W'(r_oldest) + CNT_W'(1);

    // Window update: append while filling, else replace oldest; clear the flag.
    always_comb begin
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_oldest = r_oldest;
        n_flag   = r_flag;
        wr_en    = 1'b0;
        wr_addr  = r_cnt[PTR_W-1:0];
        if (r_func == FUNC_PUT) begin
            n_flag = 1'b1;
            wr_en  = do_update;
            if (r_cnt < r_len) begin
                n_sum   = r_sum + SUM_W'(r_sample);
                n_cnt   = r_cnt + CNT_W'(1);
                wr_addr = r_cnt[PTR_W-1:0];
            end else begin
                n_sum    = r_sum - SUM_W'(r_rd_data) + SUM_W'(r_sample);
                wr_addr  = r_oldest;
                n_oldest = (oldest_inc >= r_len) ? '0 : oldest_inc[PTR_W-1:0];
            end
        end else begin
            n_flag = 1'b0;
        end
    end

    // The job carries the state as it stands after this request.
    assign o_job_sum               = n_sum;
    assign o_job_cnt               = n_cnt;
    assign o_job_flags.updated     = n_flag;
    assign o_job_flags.window_full = (n_cnt >= r_len);

    // Control state and window bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_oldest <= '0;
            r_flag   <= 1'b0;
            r_len    <= eff_len(LEN_RESET);
        end else begin
            r_state <= n_state;
            if (do_update) begin
                r_sum    <= n_sum;
                r_cnt    <= n_cnt;
                r_oldest <= n_oldest;
                r_flag   <= n_flag;
            end
            if (cfg_we) begin
                r_len    <= eff_len(i_cfg_len);
                r_sum    <= '0;
                r_cnt    <= '0;
                r_oldest <= '0;
            end
        end
    end

    // Captured request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_sample <= i_sample;
        end
    end

    // Sample ring with a registered read of the oldest entry.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_sample;
        end
        r_rd_data <= mem[r_oldest];
    end

`ifndef SYNTHESIS
    // The fill count never passes the window length.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_len)
        else $error("fill count exceeds window length");

    // The oldest pointer only moves once the window is full.
    a_oldest_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt < r_len) |-> (r_oldest == '0))
        else $error("oldest pointer moved while window filling");

    // An empty window has a zero sum.
    a_sum_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_sum == '0))
        else $error("nonzero sum with empty window");
`endif

endmodule

[hw/rtl/wma_queue.sv]
// ----------------------------------------------------------------------------
// wma_queue: short job queue between front and back
// A small first-in first-out buffer so that either side can stall alone.
// ----------------------------------------------------------------------------
module wma_queue
    import wma_pkg::*;
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_ready && o_rd_valid;

    // Pointer wrap and occupancy.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

[hw/rtl/wma_back.sv]
// ----------------------------------------------------------------------------
// wma_back: averaging divider and result register
// Divides the scaled running sum by the sample count one quotient bit per
// cycle and holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module wma_back
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW    = 64,
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Divide jobs
    input  logic                                     i_job_valid,
    output logic                                     o_job_ready,
    input  logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0] i_job_sum,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]          i_job_cnt,
    input  t_flags                                   i_job_flags,
    // Results
    output logic                                     o_empty,
    input  logic                                     i_pop,
    output logic [AVG_W-1:0]                         o_average,
    output logic                                     o_updated,
    output logic                                     o_window_full
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DIVD_W = SUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DIVD_W);

    t_back_state       r_state, n_state;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    t_flags            r_flags;
    logic              r_res_valid;
    logic [AVG_W-1:0]  r_avg;
    t_flags            r_res_flags;
    logic              last_step;
    logic              job_take;
    logic              res_load;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [AVG_W-1:0]  quo_out;

    assign last_step = (r_step == STEP_W'(DIVD_W - 1));

    // Next state of the divider.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (last_step) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_res_valid || i_pop) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Strobes of the divider.
    always_comb begin
        o_job_ready = 1'b0;
        job_take    = 1'b0;
        res_load    = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_job_ready = 1'b1;
                job_take    = i_job_valid;
            end
            B_RUN: begin
                o_job_ready = 1'b0;
            end
            B_DONE: begin
                res_load = !r_res_valid || i_pop;
            end
            default: begin
                o_job_ready = 1'b0;
            end
        endcase
    end

    // One restoring divide step: shift in a dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        n_quo = {r_quo[DIVD_W-2:0], ge};
    end

    // Fit the quotient to the average width.
    generate
        if (DIVD_W >= AVG_W) begin : g_quo_trunc
            assign quo_out = r_quo[AVG_W-1:0];
        end else begin : g_quo_ext
            assign quo_out = {{(AVG_W - DIVD_W){1'b0}}, r_quo};
        end
    endgenerate

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Divider datapath and result payload.
    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_quo   <= DIVD_W'(i_job_sum) << FRACTION_BITS;
            r_rem   <= '0;
            r_div   <= i_job_cnt;
            r_flags <= i_job_flags;
            r_step  <= '0;
        end else if (r_state == B_RUN) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_step <= r_step + STEP_W'(1);
        end
        if (res_load) begin
            r_avg       <= (r_div == '0) ? '0 : quo_out;
            r_res_flags <= r_flags;
        end
    end

    assign o_empty       = !r_res_valid;
    assign o_average     = r_avg;
    assign o_updated     = r_res_flags.updated;
    assign o_window_full = r_res_flags.window_full;

`ifndef SYNTHESIS
    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN && r_div != '0) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    // A taken job starts a division from a clear remainder.
    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE && i_job_valid) |=> (r_state == B_RUN && r_rem == '0))
        else $error("division did not start after job taken");

    // An empty window reports a zero average.
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && r_div == '0) |=> (o_average == '0 && !o_empty))
        else $error("empty window gave nonzero average");
`endif

endmodule
